// ----- hw/rtl/mpp_pkg.sv -----
// Types and constants shared by the PMT section parser.
package mpp_pkg;

    // Internal arithmetic width for position and length compares.
    localparam int CW = 14;

    localparam logic [7:0] TABLE_ID_PMT = 8'h02;
    localparam logic [7:0] TAG_CA       = 8'h09;
    localparam logic [7:0] CA_BODY_MIN  = 8'd4;

    localparam logic [7:0] VT_MPEG1     = 8'h01;
    localparam logic [7:0] VT_MPEG2     = 8'h02;
    localparam logic [7:0] VT_MPEG4     = 8'h10;
    localparam logic [7:0] VT_AVC       = 8'h1B;
    localparam logic [7:0] VT_HEVC      = 8'h24;

    // Parse phases
    localparam logic [2:0] PH_HDR   = 3'd0;
    localparam logic [2:0] PH_DTAG  = 3'd1;
    localparam logic [2:0] PH_DLEN  = 3'd2;
    localparam logic [2:0] PH_DBODY = 3'd3;
    localparam logic [2:0] PH_DSKIP = 3'd4;
    localparam logic [2:0] PH_ESH   = 3'd5;
    localparam logic [2:0] PH_EBODY = 3'd6;
    localparam logic [2:0] PH_DONE  = 3'd7;

    // Status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_SHORT     = 3'd1;
    localparam logic [2:0] ST_BAD_TID   = 3'd2;
    localparam logic [2:0] ST_TRUNC     = 3'd3;
    localparam logic [2:0] ST_PI_OVRRUN = 3'd4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] ca_system_id;
        logic [12:0] ecm_stream_pid;
        logic [12:0] video_stream_pid;
    } t_res;

    typedef struct packed {
        logic [15:0] ca_id;
        logic [12:0] ecm_pid;
        logic [12:0] es_vid_pid;
    } t_capture;

    typedef struct packed {
        logic [11:0] section_len;
        logic [11:0] info_len;
        logic [2:0]  phase;
        logic [11:0] remaining;
        logic [39:0] hdr_bytes;
        t_capture    cap;
        logic        tid_bad;
    } t_parse_state;

endpackage

// ----- hw/rtl/mpp_chan_if.sv -----
// Valid/ready channel interfaces for section bytes and parse results.
interface mpp_req_if;
    logic          valid;
    logic          ready;
    mpp_pkg::t_req payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface mpp_res_if;
    logic          valid;
    logic          ready;
    mpp_pkg::t_res payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- hw/rtl/mpeg_pmt_section_parser_core.sv -----
// Top level of the PMT section parser: request register, walker state, result register.
// Takes one PMT section byte per request, starting with the table id, and sustains one
// request per clock while no result blocks it. A byte is registered on acceptance and walked
// through the section from the request register; the request marked last loads the result
// register, so a result is valid once its last byte has been walked. Requests are refused only while
// a last byte waits behind a result that has not been taken. Bytes past MAX_SECTION_BYTES
// are dropped but a last marker on them still closes the section.
module mpeg_pmt_section_parser_core #(
    parameter int MAX_SECTION_BYTES = 4096
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    mpp_req_if.sink       i_req,
    mpp_res_if.source     o_res
);

    localparam int PW = $clog2(MAX_SECTION_BYTES + 1);

    mpp_pkg::t_req         r_in;
    logic                  r_in_vld;
    logic [PW-1:0]         r_pos;
    mpp_pkg::t_parse_state r_st;
    mpp_pkg::t_parse_state n_st;
    mpp_pkg::t_parse_state st_upd;
    mpp_pkg::t_res         r_out;
    mpp_pkg::t_res         n_out;
    logic                  r_out_vld;
    logic [PW-1:0]         n_pos;
    logic                  in_range;
    logic                  stall;
    logic                  advance;
    logic [mpp_pkg::CW-1:0] pos_ext;

    mpp_parse_step #(.PW(PW)) u_step (
        .i_state (r_st),
        .i_pos   (r_pos),
        .i_byte  (r_in.data_byte),
        .o_state (n_st)
    );

    assign stall       = r_in_vld && r_in.last_byte && r_out_vld && !o_res.ready;
    assign advance     = r_in_vld && !stall;
    assign i_req.ready = !stall;

    assign in_range = r_pos < PW'(MAX_SECTION_BYTES);
    assign n_pos    = in_range ? r_pos + PW'(1) : r_pos;
    assign st_upd   = in_range ? n_st : r_st;
    assign pos_ext  = {{(mpp_pkg::CW-PW){1'b0}}, n_pos};

    always_comb begin
        n_out = '0;
        if (pos_ext < mpp_pkg::CW'(12)) begin
            n_out.status = mpp_pkg::ST_SHORT;
        end else if (st_upd.tid_bad) begin
            n_out.status = mpp_pkg::ST_BAD_TID;
        end else if ({2'b00, st_upd.section_len} + mpp_pkg::CW'(3) > pos_ext) begin
            n_out.status = mpp_pkg::ST_TRUNC;
        end else if ({2'b00, st_upd.info_len} + mpp_pkg::CW'(13) >
                     {2'b00, st_upd.section_len}) begin
            n_out.status = mpp_pkg::ST_PI_OVRRUN;
        end else begin
            n_out.status           = mpp_pkg::ST_OK;
            n_out.ca_system_id     = st_upd.cap.ca_id;
            n_out.ecm_stream_pid   = st_upd.cap.ecm_pid;
            n_out.video_stream_pid = st_upd.cap.es_vid_pid;
        end
    end

    // the all-zero walker state is the header phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld       <= 1'b0;
            r_out_vld      <= 1'b0;
            r_pos          <= '0;
            r_st           <= '0;
        end else begin
            if (i_req.valid && i_req.ready) begin
                r_in_vld <= 1'b1;
            end else if (advance) begin
                r_in_vld <= 1'b0;
            end

            if (advance && r_in.last_byte) begin
                r_out_vld  <= 1'b1;
                r_pos      <= '0;
                r_st       <= '0;
            end else begin
                if (o_res.ready) begin
                    r_out_vld <= 1'b0;
                end
                if (advance) begin
                    r_pos <= n_pos;
                    r_st  <= st_upd;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_in <= i_req.payload;
        end
        if (advance && r_in.last_byte) begin
            r_out <= n_out;
        end
    end

    assign o_res.valid   = r_out_vld;
    assign o_res.payload = r_out;

    // a new result appears only from a processed last byte
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(advance && r_in.last_byte))
        else $error("result raised without a last byte");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.payload.status != mpp_pkg::ST_OK) |->
        (o_res.payload.ca_system_id == 16'h0000 && o_res.payload.ecm_stream_pid == 13'h0000 &&
         o_res.payload.video_stream_pid == 13'h0000))
        else $error("error result carries captured fields");

    a_pos_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= PW'(MAX_SECTION_BYTES))
        else $error("byte position beyond section limit");

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_req.ready |-> (r_in_vld && r_in.last_byte && r_out_vld))
        else $error("request refused without a blocked result");

endmodule

// ----- hw/rtl/mpp_parse_step.sv -----
// Next-state logic of the PMT walker for one section byte.
module mpp_parse_step #(
    parameter int PW = 13
) (
    input  mpp_pkg::t_parse_state i_state,
    input  logic [PW-1:0]         i_pos,
    input  logic [7:0]            i_byte,
    output mpp_pkg::t_parse_state o_state
);

    // Pick the phase for the byte at position q.
    function automatic mpp_pkg::t_parse_state f_plan(
        input mpp_pkg::t_parse_state s,
        input logic [mpp_pkg::CW-1:0] q,
        input logic [mpp_pkg::CW-1:0] dend
    );
        mpp_pkg::t_parse_state r;
        r = s;
        if (q < dend) begin
            r.phase = (q + mpp_pkg::CW'(2) <= dend) ? mpp_pkg::PH_DTAG : mpp_pkg::PH_DSKIP;
        end else if (q + mpp_pkg::CW'(6) <= {2'b00, s.section_len}) begin
            r.phase     = mpp_pkg::PH_ESH;
            r.remaining = '0;
            r.hdr_bytes = '0;
        end else begin
            r.phase = mpp_pkg::PH_DONE;
        end
        return r;
    endfunction

    function automatic logic f_is_video(input logic [7:0] t);
        return t == mpp_pkg::VT_MPEG1 || t == mpp_pkg::VT_MPEG2 || t == mpp_pkg::VT_MPEG4 ||
               t == mpp_pkg::VT_AVC   || t == mpp_pkg::VT_HEVC;
    endfunction

    logic [mpp_pkg::CW-1:0] p;
    logic [mpp_pkg::CW-1:0] q;
    logic [mpp_pkg::CW-1:0] dend;
    logic [mpp_pkg::CW-1:0] dend_new;
    logic [11:0]            info_new;
    logic [7:0]             want;
    logic [31:0]            low;
    logic [39:0]            shifted;
    logic [11:0]            rem_dec;
    logic [11:0]            rem_inc;
    logic [11:0]            esl;

    always_comb begin
        o_state  = i_state;
        p        = {{(mpp_pkg::CW-PW){1'b0}}, i_pos};
        q        = p + mpp_pkg::CW'(1);
        dend     = mpp_pkg::CW'(12) + {2'b00, i_state.info_len};
        info_new = i_state.info_len | {4'h0, i_byte};
        dend_new = mpp_pkg::CW'(12) + {2'b00, info_new};
        want     = i_state.hdr_bytes[39:32];
        low      = {i_state.hdr_bytes[23:0], i_byte};
        shifted  = {i_state.hdr_bytes[31:0], i_byte};
        rem_dec  = i_state.remaining - 12'd1;
        rem_inc  = i_state.remaining + 12'd1;
        esl      = shifted[11:0];

        case (i_state.phase)
            mpp_pkg::PH_HDR: begin
                if (p == mpp_pkg::CW'(0)) begin
                    o_state.tid_bad = (i_byte != mpp_pkg::TABLE_ID_PMT);
                end else if (p == mpp_pkg::CW'(1)) begin
                    o_state.section_len = {i_byte[3:0], 8'h00};
                end else if (p == mpp_pkg::CW'(2)) begin
                    o_state.section_len = i_state.section_len | {4'h0, i_byte};
                end else if (p == mpp_pkg::CW'(10)) begin
                    o_state.info_len = {i_byte[3:0], 8'h00};
                end else if (p == mpp_pkg::CW'(11)) begin
                    o_state.info_len = info_new;
                    if (dend_new + mpp_pkg::CW'(1) > {2'b00, i_state.section_len}) begin
                        o_state.phase = mpp_pkg::PH_DONE;
                    end else begin
                        o_state = f_plan(o_state, mpp_pkg::CW'(12), dend_new);
                    end
                end
            end
            mpp_pkg::PH_DTAG: begin
                o_state.hdr_bytes = {32'h0, i_byte};
                o_state.phase     = mpp_pkg::PH_DLEN;
            end
            mpp_pkg::PH_DLEN: begin
                if (q + {6'h00, i_byte} > dend) begin
                    // descriptor runs past program info: skip the rest of it
                    if (q < dend) begin
                        o_state.phase = mpp_pkg::PH_DSKIP;
                    end else begin
                        o_state = f_plan(o_state, q, dend);
                    end
                end else begin
                    o_state.hdr_bytes = (i_state.hdr_bytes == {32'h0, mpp_pkg::TAG_CA} &&
                                         i_byte >= mpp_pkg::CA_BODY_MIN) ?
                                        {8'd4, 32'h0} : 40'h0;
                    o_state.remaining = {4'h0, i_byte};
                    if (i_byte == 8'h00) begin
                        o_state = f_plan(o_state, q, dend);
                    end else begin
                        o_state.phase = mpp_pkg::PH_DBODY;
                    end
                end
            end
            mpp_pkg::PH_DBODY: begin
                if (want != 8'h00) begin
                    o_state.hdr_bytes = {want - 8'd1, low};
                    if (want == 8'd1) begin
                        o_state.cap.ca_id   = low[31:16];
                        o_state.cap.ecm_pid = low[12:0];
                    end
                end
                o_state.remaining = rem_dec;
                if (rem_dec == 12'h000) begin
                    o_state = f_plan(o_state, q, dend);
                end
            end
            mpp_pkg::PH_DSKIP: begin
                if (q >= dend) begin
                    o_state = f_plan(o_state, q, dend);
                end
            end
            mpp_pkg::PH_ESH: begin
                o_state.hdr_bytes = shifted;
                o_state.remaining = rem_inc;
                if (rem_inc >= 12'd5) begin
                    if (q + {2'b00, esl} + mpp_pkg::CW'(1) > {2'b00, i_state.section_len}) begin
                        o_state.phase = mpp_pkg::PH_DONE;
                    end else begin
                        // zero PID counts as not found yet
                        if (i_state.cap.es_vid_pid == 13'h0000 && f_is_video(shifted[39:32])) begin
                            o_state.cap.es_vid_pid = shifted[28:16];
                        end
                        o_state.remaining = esl;
                        if (esl == 12'h000) begin
                            o_state = f_plan(o_state, q, dend);
                        end else begin
                            o_state.phase = mpp_pkg::PH_EBODY;
                        end
                    end
                end
            end
            mpp_pkg::PH_EBODY: begin
                o_state.remaining = rem_dec;
                if (rem_dec == 12'h000) begin
                    o_state = f_plan(o_state, q, dend);
                end
            end
            default: begin
                o_state = i_state;
            end
        endcase
    end

endmodule

// ----- bench/tb_mpeg_pmt_section_parser_core.sv -----
// Self-checking testbench for the PMT section parser: directed table, then random sections.
`timescale 1ns / 1ps

module tb_mpeg_pmt_section_parser_core;

    localparam int SECTION_BYTES_MAX = 4096;
    localparam int CYCLE_LIMIT       = 400000;
    localparam int ITEMS_PER_PHASE   = 450;
    localparam int DRAIN_CYCLES      = 20;

    typedef enum int {
        SEC_GOOD,
        SEC_TRUNC,
        SEC_OVERRUN,
        SEC_BAD_TID,
        SEC_NOISE
    } t_section_kind;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       pinned;
        logic [2:0] status;
    } t_dir_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    mpp_req_if req_if ();
    mpp_res_if res_if ();

    mpeg_pmt_section_parser_core #(
        .MAX_SECTION_BYTES(SECTION_BYTES_MAX)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Directed rows: one-byte section, bad table id, length running past the data.
    t_dir_row dir_rows [25] = '{
        '{8'hFF, 1'b1, 1'b1, mpp_pkg::ST_SHORT},
        '{8'h00, 1'b0, 1'b0, mpp_pkg::ST_OK},
        '{8'hB0, 1'b0, 1'b0, mpp_pkg::ST_OK},
        '{8'h0D, 1'b0, 1'b0, mpp_pkg::ST_OK},
        '{8'h00, 1'b0, 1'b0, mpp_pkg::ST_OK},
        '{8'h01, 1'b0, 1'b0, mpp_pkg::ST_OK},
        '{8'hC1, 1'b0, 1'b0, mpp_pkg::ST_OK},
        '{8'h00, 1'b0, 1'b0, mpp_pkg::ST_OK},
        '{8'h00, 1'b0, 1'b0, mpp_pkg::ST_OK},
        '{8'hE1, 1'b0, 1'b0, mpp_pkg::ST_OK},
        '{8'h00, 1'b0, 1'b0, mpp_pkg::ST_OK},
        '{8'hF0, 1'b0, 1'b0, mpp_pkg::ST_OK},
        '{8'h00, 1'b1, 1'b1, mpp_pkg::ST_BAD_TID},
        '{8'h02, 1'b0, 1'b0, mpp_pkg::ST_OK},
        '{8'hFF, 1'b0, 1'b0, mpp_pkg::ST_OK},
        '{8'hFF, 1'b0, 1'b0, mpp_pkg::ST_OK},
        '{8'hFF, 1'b0, 1'b0, mpp_pkg::ST_OK},
        '{8'hFF, 1'b0, 1'b0, mpp_pkg::ST_OK},
        '{8'hFF, 1'b0, 1'b0, mpp_pkg::ST_OK},
        '{8'hFF, 1'b0, 1'b0, mpp_pkg::ST_OK},
        '{8'hFF, 1'b0, 1'b0, mpp_pkg::ST_OK},
        '{8'hFF, 1'b0, 1'b0, mpp_pkg::ST_OK},
        '{8'hFF, 1'b0, 1'b0, mpp_pkg::ST_OK},
        '{8'hFF, 1'b0, 1'b0, mpp_pkg::ST_OK},
        '{8'hFF, 1'b1, 1'b1, mpp_pkg::ST_TRUNC}
    };

    // Section walker mirror
    int                 pos_cnt     = 0;
    logic [11:0]        len_sec     = '0;
    logic [11:0]        len_info    = '0;
    logic [2:0]         walk_phase  = mpp_pkg::PH_HDR;
    logic [11:0]        item_left   = '0;
    logic [39:0]        item_hdr    = '0;
    mpp_pkg::t_capture  cap_now     = '0;
    logic               tid_wrong   = 1'b0;

    mpp_pkg::t_res      expected_sections [$];
    logic [7:0]         sec_bytes [$];

    int                 mismatches  = 0;
    int                 cycle_count = 0;
    int                 tx_idle_pct = 0;
    int                 rx_idle_pct = 0;
    logic               pin_use     = 1'b0;
    logic [2:0]         pin_status  = mpp_pkg::ST_OK;

    function automatic int loop_end();
        return int'(len_sec) - 1;
    endfunction

    function automatic int info_end();
        return 12 + int'(len_info);
    endfunction

    // pick the phase for the byte at position q
    function automatic void plan_next(int q);
        int dend = info_end();
        if (q < dend) begin
            walk_phase = (q + 2 <= dend) ? mpp_pkg::PH_DTAG : mpp_pkg::PH_DSKIP;
        end else if (q + 5 <= loop_end()) begin
            walk_phase = mpp_pkg::PH_ESH;
            item_left  = '0;
            item_hdr   = '0;
        end else begin
            walk_phase = mpp_pkg::PH_DONE;
        end
    endfunction

    function automatic void walk_pmt_byte(int p, logic [7:0] b);
        int          q = p + 1;
        logic [7:0]  want;
        logic [31:0] low;
        logic [7:0]  stype;
        logic [12:0] pid;
        logic [11:0] esl;
        case (walk_phase)
            mpp_pkg::PH_HDR: begin
                if (p == 0) begin
                    tid_wrong = (b != mpp_pkg::TABLE_ID_PMT);
                end else if (p == 1) begin
                    len_sec = {b[3:0], 8'h00};
                end else if (p == 2) begin
                    len_sec = len_sec | {4'h0, b};
                end else if (p == 10) begin
                    len_info = {b[3:0], 8'h00};
                end else if (p == 11) begin
                    len_info = len_info | {4'h0, b};
                    if (info_end() > loop_end()) walk_phase = mpp_pkg::PH_DONE;
                    else plan_next(12);
                end
            end
            mpp_pkg::PH_DTAG: begin
                item_hdr   = {32'd0, b};
                walk_phase = mpp_pkg::PH_DLEN;
            end
            mpp_pkg::PH_DLEN: begin
                if (q + int'(b) > info_end()) begin
                    if (q < info_end()) walk_phase = mpp_pkg::PH_DSKIP;
                    else plan_next(q);
                end else begin
                    want      = (item_hdr == {32'd0, mpp_pkg::TAG_CA} &&
                                 b >= mpp_pkg::CA_BODY_MIN) ? 8'd4 : 8'd0;
                    item_hdr  = {want, 32'd0};
                    item_left = {4'h0, b};
                    if (b == 8'd0) plan_next(q);
                    else walk_phase = mpp_pkg::PH_DBODY;
                end
            end
            mpp_pkg::PH_DBODY: begin
                want = item_hdr[39:32];
                if (want != 8'd0) begin
                    low      = {item_hdr[23:0], b};
                    want     = want - 8'd1;
                    item_hdr = {want, low};
                    if (want == 8'd0) begin
                        cap_now.ca_id   = low[31:16];
                        cap_now.ecm_pid = low[12:0];
                    end
                end
                item_left = item_left - 12'd1;
                if (item_left == 12'd0) plan_next(q);
            end
            mpp_pkg::PH_DSKIP: begin
                if (q >= info_end()) plan_next(q);
            end
            mpp_pkg::PH_ESH: begin
                item_hdr  = {item_hdr[31:0], b};
                item_left = item_left + 12'd1;
                if (item_left >= 12'd5) begin
                    stype = item_hdr[39:32];
                    pid   = item_hdr[28:16];
                    esl   = item_hdr[11:0];
                    if (q + int'(esl) > loop_end()) begin
                        walk_phase = mpp_pkg::PH_DONE;
                    end else begin
                        if (cap_now.es_vid_pid == 13'd0 &&
                            (stype == mpp_pkg::VT_MPEG1 || stype == mpp_pkg::VT_MPEG2 ||
                             stype == mpp_pkg::VT_MPEG4 || stype == mpp_pkg::VT_AVC ||
                             stype == mpp_pkg::VT_HEVC)) begin
                            cap_now.es_vid_pid = pid;
                        end
                        item_left = esl;
                        if (esl == 12'd0) plan_next(q);
                        else walk_phase = mpp_pkg::PH_EBODY;
                    end
                end
            end
            mpp_pkg::PH_EBODY: begin
                item_left = item_left - 12'd1;
                if (item_left == 12'd0) plan_next(q);
            end
            default: begin
            end
        endcase
    endfunction

    // returns 1 when the request closes a section; res then holds its result
    function automatic logic walk_request(input mpp_pkg::t_req r, output mpp_pkg::t_res res);
        res = '0;
        if (pos_cnt < SECTION_BYTES_MAX) begin
            walk_pmt_byte(pos_cnt, r.data_byte);
            pos_cnt = pos_cnt + 1;
        end
        if (!r.last_byte) return 1'b0;

        if (pos_cnt < 12) begin
            res.status = mpp_pkg::ST_SHORT;
        end else if (tid_wrong) begin
            res.status = mpp_pkg::ST_BAD_TID;
        end else if (int'(len_sec) + 3 > pos_cnt) begin
            res.status = mpp_pkg::ST_TRUNC;
        end else if (info_end() > loop_end()) begin
            res.status = mpp_pkg::ST_PI_OVRRUN;
        end else begin
            res.status           = mpp_pkg::ST_OK;
            res.ca_system_id     = cap_now.ca_id;
            res.ecm_stream_pid   = cap_now.ecm_pid;
            res.video_stream_pid = cap_now.es_vid_pid;
        end

        pos_cnt    = 0;
        len_sec    = '0;
        len_info   = '0;
        walk_phase = mpp_pkg::PH_HDR;
        item_left  = '0;
        item_hdr   = '0;
        cap_now    = '0;
        tid_wrong  = 1'b0;
        return 1'b1;
    endfunction

    function automatic void compose_section(t_section_kind kind);
        logic [7:0]  pi_b [$];
        logic [7:0]  es_b [$];
        logic [7:0]  vtypes [5] = '{mpp_pkg::VT_MPEG1, mpp_pkg::VT_MPEG2, mpp_pkg::VT_MPEG4,
                                    mpp_pkg::VT_AVC, mpp_pkg::VT_HEVC};
        int          n_items;
        int          len;
        int          sl;
        int          pl;
        logic [7:0]  tag;
        logic [7:0]  stype;
        logic [12:0] pid;
        sec_bytes.delete();
        if (kind == SEC_NOISE) begin
            repeat ($urandom_range(1, 20)) sec_bytes.push_back(8'($urandom));
            return;
        end

        n_items = $urandom_range(0, 3);
        repeat (n_items) begin
            tag = $urandom_range(1) ? mpp_pkg::TAG_CA : 8'($urandom);
            len = $urandom_range(0, 8);
            pi_b.push_back(tag);
            pi_b.push_back(8'(len));
            repeat (len) pi_b.push_back(8'($urandom));
        end
        // descriptor cut short by the end of the program info
        if ($urandom_range(99) < 15) begin
            pi_b.push_back($urandom_range(1) ? mpp_pkg::TAG_CA : 8'($urandom));
            if ($urandom_range(1)) begin
                len = $urandom_range(1, 20);
                pi_b.push_back(8'(len));
                repeat ($urandom_range(0, len - 1) % 4) pi_b.push_back(8'($urandom));
            end
        end

        n_items = $urandom_range(0, 3);
        repeat (n_items) begin
            stype = ($urandom_range(99) < 60) ? vtypes[$urandom_range(4)] : 8'($urandom);
            pid   = ($urandom_range(99) < 10) ? 13'd0 : 13'($urandom);
            len   = $urandom_range(0, 6);
            es_b.push_back(stype);
            es_b.push_back({3'($urandom), pid[12:8]});
            es_b.push_back(pid[7:0]);
            es_b.push_back({4'($urandom), 4'(len >> 8)});
            es_b.push_back(8'(len));
            repeat (len) es_b.push_back(8'($urandom));
        end
        // partial stream header, or stream info reaching past the section
        if ($urandom_range(99) < 15) begin
            if ($urandom_range(1)) begin
                repeat ($urandom_range(1, 4)) es_b.push_back(8'($urandom));
            end else begin
                len = $urandom_range(1, 4095);
                es_b.push_back(vtypes[$urandom_range(4)]);
                es_b.push_back(8'($urandom));
                es_b.push_back(8'($urandom));
                es_b.push_back({4'($urandom), 4'(len >> 8)});
                es_b.push_back(8'(len));
                repeat ($urandom_range(0, 3)) es_b.push_back(8'($urandom));
            end
        end

        pl = pi_b.size();
        sl = 9 + pl + es_b.size() + 4;
        if (kind == SEC_OVERRUN) begin
            pl = ($urandom_range(9) == 0) ? $urandom_range(0, 4095)
                                          : pl + es_b.size() + 1 + $urandom_range(0, 3);
        end
        if (kind == SEC_TRUNC && $urandom_range(2) == 0) sl = $urandom_range(0, 4095);

        tag = mpp_pkg::TABLE_ID_PMT;
        if (kind == SEC_BAD_TID) begin
            tag = 8'($urandom);
            if (tag == mpp_pkg::TABLE_ID_PMT) tag = ~tag;
        end
        sec_bytes.push_back(tag);
        sec_bytes.push_back({4'($urandom), 4'(sl >> 8)});
        sec_bytes.push_back(8'(sl));
        repeat (7) sec_bytes.push_back(8'($urandom));
        sec_bytes.push_back({4'($urandom), 4'(pl >> 8)});
        sec_bytes.push_back(8'(pl));
        foreach (pi_b[i]) sec_bytes.push_back(pi_b[i]);
        foreach (es_b[i]) sec_bytes.push_back(es_b[i]);
        repeat (4) sec_bytes.push_back(8'($urandom));

        if (kind == SEC_TRUNC) begin
            repeat ($urandom_range(1, 8)) begin
                if (sec_bytes.size() > 1) sec_bytes.delete(sec_bytes.size() - 1);
            end
        end
        if (kind == SEC_GOOD && $urandom_range(3) == 0) begin
            repeat ($urandom_range(1, 6)) sec_bytes.push_back(8'($urandom));
        end
    endfunction

    task automatic report_mismatch(string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        mismatches = mismatches + 1;
    endtask

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_request(logic [7:0] b, logic last, logic pin, logic [2:0] status);
        while ($urandom_range(99) < tx_idle_pct) begin
            req_if.valid = 1'b0;
            @(negedge i_clk);
        end
        req_if.valid             = 1'b1;
        req_if.payload.data_byte = b;
        req_if.payload.last_byte = last;
        pin_use                  = pin;
        pin_status               = status;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_section();
        foreach (sec_bytes[i]) begin
            send_request(sec_bytes[i], i == sec_bytes.size() - 1, 1'b0, mpp_pkg::ST_OK);
        end
    endtask

    always @(negedge i_clk) begin
        res_if.ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge i_clk) begin : scoreboard
        mpp_pkg::t_res predicted;
        mpp_pkg::t_res want;
        mpp_pkg::t_res seen;
        if (req_if.valid && req_if.ready) begin
            if (walk_request(req_if.payload, predicted)) begin
                if (pin_use) begin
                    predicted        = '0;
                    predicted.status = pin_status;
                end
                expected_sections.push_back(predicted);
            end
        end
        if (res_if.valid && res_if.ready) begin
            seen = res_if.payload;
            if (expected_sections.size() == 0) begin
                report_mismatch($sformatf("result with none expected: status %0d", seen.status));
            end else begin
                want = expected_sections.pop_front();
                if (seen.status !== want.status)
                    report_mismatch($sformatf("status: expected %0d, got %0d",
                                              want.status, seen.status));
                if (seen.ca_system_id !== want.ca_system_id)
                    report_mismatch($sformatf("ca_system_id: expected %h, got %h",
                                              want.ca_system_id, seen.ca_system_id));
                if (seen.ecm_stream_pid !== want.ecm_stream_pid)
                    report_mismatch($sformatf("ecm_stream_pid: expected %h, got %h",
                                              want.ecm_stream_pid, seen.ecm_stream_pid));
                if (seen.video_stream_pid !== want.video_stream_pid)
                    report_mismatch($sformatf("video_stream_pid: expected %h, got %h",
                                              want.video_stream_pid, seen.video_stream_pid));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout with %0d results outstanding", expected_sections.size());
            $display("tb_mpeg_pmt_section_parser_core NOT OK");
            $finish;
        end
    end

    initial begin : stimulus
        int            sent;
        int            pick;
        t_section_kind kind;
        i_rst_n        = 1'b0;
        req_if.valid   = 1'b0;
        req_if.payload = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        tx_idle_pct = 10;
        rx_idle_pct = 88;
        foreach (dir_rows[i]) begin
            send_request(dir_rows[i].data, dir_rows[i].last, dir_rows[i].pinned,
                         dir_rows[i].status);
        end

        for (int ph = 0; ph < 3; ph++) begin
            tx_idle_pct = (ph == 0) ? 10 : (ph == 1) ? 88 : 0;
            rx_idle_pct = (ph == 0) ? 88 : (ph == 1) ? 10 : 0;
            sent = 0;
            while (sent < ITEMS_PER_PHASE) begin
                pick = $urandom_range(99);
                kind = (pick < 68) ? SEC_GOOD    :
                       (pick < 76) ? SEC_TRUNC   :
                       (pick < 83) ? SEC_OVERRUN :
                       (pick < 88) ? SEC_BAD_TID : SEC_NOISE;
                compose_section(kind);
                send_section();
                sent = sent + sec_bytes.size();
            end
        end

        req_if.valid = 1'b0;
        while (expected_sections.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb_mpeg_pmt_section_parser_core OK");
        end else begin
            $display("tb_mpeg_pmt_section_parser_core NOT OK");
        end
        $finish;
    end

endmodule
